// ===== src/vsr_pkg.sv =====
// Shared types and constants of the vector specular reflection unit.
`default_nettype none

package vsr_pkg;

	// Request: surface normal and incident direction, signed Q2.14.
	typedef struct packed {
		logic signed [15:0] normal_r;
		logic signed [15:0] normal_z;
		logic signed [15:0] incident_r;
		logic signed [15:0] incident_z;
	} ray_t;

	// Result: reflected direction and the angle to the normal.
	typedef struct packed {
		logic signed [15:0] reflected_r;
		logic signed [15:0] reflected_z;
		logic        [15:0] angle;
	} refl_t;

	// Reflected direction alone, carried alongside the arccosine work.
	typedef struct packed {
		logic signed [15:0] reflected_r;
		logic signed [15:0] reflected_z;
	} dir_t;

	// Arccosine argument in Q30, held within [-1, 1].
	localparam int XQ_W = 32;

	// Square root of 1 - x*x: radicand width, result width and step count.
	localparam int SQ_W        = 62;
	localparam int Y_W         = 31;
	localparam int SQRT_STEPS  = 31;
	localparam logic [SQ_W-1:0] ONE_Q60 = 62'h1000000000000000;

	// Vectoring rotation: datapath width, step count and angle table in Q30.
	localparam int CW           = 34;
	localparam int CORDIC_STEPS = 30;
	localparam logic signed [CW-1:0] HALF_PI_Q30 = 34'sd1686629713;

	localparam logic [31:0] ATAN_Q30 [CORDIC_STEPS] = '{
		32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
		32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
		32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
		32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
		32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
		32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002
	};

endpackage

`default_nettype wire

// ===== src/vsr_reflect.sv =====
// Reflection r = i - 2(n.i)n, then d = n.r clamped and scaled to a Q30 argument.
`default_nettype none

module vsr_reflect #(
	parameter int FRAC_BITS = 14
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              adv,
	input  logic                              in_valid,
	input  vsr_pkg::ray_t                     ray,
	output logic                              out_valid,
	output vsr_pkg::dir_t                     dir,
	output logic signed [vsr_pkg::XQ_W-1:0]   xq
);
	import vsr_pkg::*;

	localparam int F2  = 2 * FRAC_BITS;
	localparam int RSH = (F2 >= 30) ? F2 - 30 : 0;
	localparam int LSH = (F2 < 30) ? 30 - F2 : 0;
	localparam logic signed [63:0] RND_R = 64'sd1 <<< (F2 - 1);
	localparam logic signed [63:0] RND_X =
		(RSH > 0) ? (64'sd1 <<< ((RSH > 0) ? RSH - 1 : 0)) : 64'sd0;
	localparam logic signed [63:0] LIM   = 64'sd1 <<< F2;
	localparam logic signed [63:0] ONE_X = 64'sd1 <<< 30;

	function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
		logic signed [15:0] r;
		if (v > 64'sd32767) begin
			r = 16'sh7FFF;
		end else if (v < -64'sd32768) begin
			r = -16'sd32768;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

	logic signed [15:0] nr, nz, ir, iz;
	assign nr = ray.normal_r;
	assign nz = ray.normal_z;
	assign ir = ray.incident_r;
	assign iz = ray.incident_z;

	logic                vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic signed [15:0]  nr_s1, nz_s1, ir_s1, iz_s1;
	logic signed [31:0]  pr_s1, pz_s1;
	logic signed [15:0]  nr_s2, nz_s2, ir_s2, iz_s2;
	logic signed [32:0]  dot_s2;
	logic signed [15:0]  nr_s3, nz_s3, ir_s3, iz_s3;
	logic signed [48:0]  mr_s3, mz_s3;
	logic signed [15:0]  nr_s4, nz_s4, rr_s4, rz_s4;
	logic signed [31:0]  qr_s5, qz_s5;
	logic signed [15:0]  rr_s5, rz_s5;
	logic signed [32:0]  d_s6;
	logic signed [15:0]  rr_s6, rz_s6;
	logic signed [XQ_W-1:0] xq_s7;
	logic signed [15:0]  rr_s7, rz_s7;

	logic signed [63:0] tr, tz, er, ez;
	logic signed [63:0] dw, dc, xs, xc;

	// Stage 4: round 2*c*n back to the input scale and subtract from i.
	always_comb begin
		tr = ($signed({{14{mr_s3[48]}}, mr_s3, 1'b0}) + RND_R) >>> F2;
		tz = ($signed({{14{mz_s3[48]}}, mz_s3, 1'b0}) + RND_R) >>> F2;
		er = {{48{ir_s3[15]}}, ir_s3} - tr;
		ez = {{48{iz_s3[15]}}, iz_s3} - tz;
	end

	// Stage 7: clamp n.r to one, then bring it to Q30 with rounding.
	always_comb begin
		dw = {{31{d_s6[32]}}, d_s6};
		if (dw > LIM) begin
			dc = LIM;
		end else if (dw < -LIM) begin
			dc = -LIM;
		end else begin
			dc = dw;
		end
		xs = ((dc + RND_X) >>> RSH) <<< LSH;
		if (xs > ONE_X) begin
			xc = ONE_X;
		end else if (xs < -ONE_X) begin
			xc = -ONE_X;
		end else begin
			xc = xs;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			nr_s1  <= nr;
			nz_s1  <= nz;
			ir_s1  <= ir;
			iz_s1  <= iz;
			pr_s1  <= 32'(nr) * 32'(ir);
			pz_s1  <= 32'(nz) * 32'(iz);

			nr_s2  <= nr_s1;
			nz_s2  <= nz_s1;
			ir_s2  <= ir_s1;
			iz_s2  <= iz_s1;
			dot_s2 <= 33'(pr_s1) + 33'(pz_s1);

			nr_s3  <= nr_s2;
			nz_s3  <= nz_s2;
			ir_s3  <= ir_s2;
			iz_s3  <= iz_s2;
			mr_s3  <= 49'(dot_s2) * 49'(nr_s2);
			mz_s3  <= 49'(dot_s2) * 49'(nz_s2);

			nr_s4  <= nr_s3;
			nz_s4  <= nz_s3;
			rr_s4  <= sat16(er);
			rz_s4  <= sat16(ez);

			rr_s5  <= rr_s4;
			rz_s5  <= rz_s4;
			qr_s5  <= 32'(nr_s4) * 32'(rr_s4);
			qz_s5  <= 32'(nz_s4) * 32'(rz_s4);

			rr_s6  <= rr_s5;
			rz_s6  <= rz_s5;
			d_s6   <= 33'(qr_s5) + 33'(qz_s5);

			rr_s7  <= rr_s6;
			rz_s7  <= rz_s6;
			xq_s7  <= xc[XQ_W-1:0];
		end
	end

	assign out_valid       = vld_s7;
	assign dir.reflected_r = rr_s7;
	assign dir.reflected_z = rz_s7;
	assign xq              = xq_s7;

endmodule

`default_nettype wire

// ===== src/vsr_isqrt.sv =====
// Pipelined floor square root of 1 - x*x, one result bit per root step.
`default_nettype none

module vsr_isqrt (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              adv,
	input  logic                              in_valid,
	input  vsr_pkg::dir_t                     dir_in,
	input  logic signed [vsr_pkg::XQ_W-1:0]   xq_in,
	output logic                              out_valid,
	output vsr_pkg::dir_t                     dir_out,
	output logic signed [vsr_pkg::XQ_W-1:0]   xq_out,
	output logic        [vsr_pkg::Y_W-1:0]    y
);
	import vsr_pkg::*;

	logic signed [XQ_W-1:0] xa;
	logic        [Y_W-1:0]  ax;

	logic                   vld_s1;
	logic        [SQ_W-1:0] sq_s1;
	dir_t                   dir_s1;
	logic signed [XQ_W-1:0] xq_s1;

	// Index 0 holds the radicand stage; index j+1 follows root step j.
	logic [SQRT_STEPS:0]    vld_s;
	logic        [SQ_W-1:0] rem_s [0:SQRT_STEPS];
	logic        [SQ_W-1:0] res_s [0:SQRT_STEPS];
	dir_t                   dir_s [0:SQRT_STEPS];
	logic signed [XQ_W-1:0] xq_s  [0:SQRT_STEPS];

	assign xa = (xq_in < 0) ? -xq_in : xq_in;
	assign ax = xa[Y_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s  <= '0;
		end else if (adv) begin
			vld_s1 <= in_valid;
			vld_s  <= {vld_s[SQRT_STEPS-1:0], vld_s1};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_s1    <= SQ_W'(ax) * SQ_W'(ax);
			dir_s1   <= dir_in;
			xq_s1    <= xq_in;
			rem_s[0] <= ONE_Q60 - sq_s1;
			res_s[0] <= '0;
			dir_s[0] <= dir_s1;
			xq_s[0]  <= xq_s1;
		end
	end

	for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_step
		localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (60 - 2 * j);
		logic [SQ_W-1:0] trial;
		logic            take;

		assign trial = res_s[j] + BIT;
		assign take  = (rem_s[j] >= trial);

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[j+1] <= take ? rem_s[j] - trial : rem_s[j];
				res_s[j+1] <= take ? (res_s[j] >> 1) + BIT : res_s[j] >> 1;
				dir_s[j+1] <= dir_s[j];
				xq_s[j+1]  <= xq_s[j];
			end
		end
	end

	assign out_valid = vld_s[SQRT_STEPS];
	assign dir_out   = dir_s[SQRT_STEPS];
	assign xq_out    = xq_s[SQRT_STEPS];
	assign y         = res_s[SQRT_STEPS][Y_W-1:0];

endmodule

`default_nettype wire

// ===== src/vsr_cordic.sv =====
// Vectoring rotation giving atan2(y, x) as the arccosine, then rounding to the output angle.
`default_nettype none

module vsr_cordic #(
	parameter int FRAC_BITS = 14
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              adv,
	input  logic                              in_valid,
	input  vsr_pkg::dir_t                     dir_in,
	input  logic signed [vsr_pkg::XQ_W-1:0]   xq_in,
	input  logic        [vsr_pkg::Y_W-1:0]    y_in,
	output logic                              out_valid,
	output vsr_pkg::refl_t                    result
);
	import vsr_pkg::*;

	localparam int RS = 30 - FRAC_BITS;
	localparam logic signed [35:0] RND_A =
		(RS > 0) ? (36'sd1 <<< ((RS > 0) ? RS - 1 : 0)) : 36'sd0;

	// Index 0 is the quadrant fold; index i+1 follows rotation step i.
	logic [CORDIC_STEPS:0]  vld_s;
	logic signed [CW-1:0]   cx_s  [0:CORDIC_STEPS];
	logic signed [CW-1:0]   cy_s  [0:CORDIC_STEPS];
	logic signed [CW-1:0]   ang_s [0:CORDIC_STEPS];
	dir_t                   dir_s [0:CORDIC_STEPS];

	logic                   vld_s31;
	dir_t                   dir_s31;
	logic [15:0]            angle_s31;

	logic signed [CW-1:0]   xe, ye;
	logic signed [35:0]     ar;
	logic [15:0]            ac;

	assign xe = CW'(xq_in);
	assign ye = signed'(CW'(y_in));

	// A negative argument is turned a quarter turn so the rotation starts at x >= 0.
	always_ff @(posedge clk) begin
		if (adv) begin
			dir_s[0] <= dir_in;
			if (xq_in < 0) begin
				cx_s[0]  <= ye;
				cy_s[0]  <= -xe;
				ang_s[0] <= HALF_PI_Q30;
			end else begin
				cx_s[0]  <= xe;
				cy_s[0]  <= ye;
				ang_s[0] <= '0;
			end
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
		localparam logic signed [CW-1:0] AT = signed'(CW'(ATAN_Q30[i]));
		logic signed [CW-1:0] xs, ys;

		assign xs = cx_s[i] >>> i;
		assign ys = cy_s[i] >>> i;

		always_ff @(posedge clk) begin
			if (adv) begin
				dir_s[i+1] <= dir_s[i];
				if (cy_s[i] > 0) begin
					cx_s[i+1]  <= cx_s[i] + ys;
					cy_s[i+1]  <= cy_s[i] - xs;
					ang_s[i+1] <= ang_s[i] + AT;
				end else if (cy_s[i] < 0) begin
					cx_s[i+1]  <= cx_s[i] - ys;
					cy_s[i+1]  <= cy_s[i] + xs;
					ang_s[i+1] <= ang_s[i] - AT;
				end else begin
					cx_s[i+1]  <= cx_s[i];
					cy_s[i+1]  <= cy_s[i];
					ang_s[i+1] <= ang_s[i];
				end
			end
		end
	end

	// Round the Q30 angle to the output scale and hold it to sixteen bits.
	always_comb begin
		ar = (36'(ang_s[CORDIC_STEPS]) + RND_A) >>> RS;
		if (ar < 0) begin
			ac = 16'd0;
		end else if (ar > 36'sd65535) begin
			ac = 16'hFFFF;
		end else begin
			ac = ar[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s   <= '0;
			vld_s31 <= 1'b0;
		end else if (adv) begin
			vld_s   <= {vld_s[CORDIC_STEPS-1:0], in_valid};
			vld_s31 <= vld_s[CORDIC_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dir_s31   <= dir_s[CORDIC_STEPS];
			angle_s31 <= ac;
		end
	end

	assign out_valid          = vld_s31;
	assign result.reflected_r = dir_s31.reflected_r;
	assign result.reflected_z = dir_s31.reflected_z;
	assign result.angle       = angle_s31;

endmodule

`default_nettype wire

// ===== src/vsr_out_buf.sv =====
// Two-entry output buffer that lets the pipeline run while a result is held.
`default_nettype none

module vsr_out_buf (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  vsr_pkg::refl_t din,
	output logic           valid,
	input  logic           stall,
	output vsr_pkg::refl_t dout,
	output logic           full
);
	import vsr_pkg::*;

	logic [1:0] cnt_q;
	refl_t      head_q;
	refl_t      spare_q;
	logic       pop;

	assign pop   = (cnt_q != 2'd0) && !stall;
	assign valid = (cnt_q != 2'd0);
	assign full  = (cnt_q == 2'd2);
	assign dout  = head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= 2'(cnt_q + {1'b0, push} - {1'b0, pop});
		end
	end

	// The head always holds the oldest result; the spare fills only behind a held head.
	always_ff @(posedge clk) begin
		if (cnt_q == 2'd2) begin
			if (pop) begin
				head_q <= spare_q;
			end
		end else if (push) begin
			if (cnt_q == 2'd0 || pop) begin
				head_q <= din;
			end else begin
				spare_q <= din;
			end
		end
	end

endmodule

`default_nettype wire

// ===== src/vector_specular_reflection_unit.sv =====
// Top level of the 2D specular reflection unit with reflection angle.
//
//   channel  direction  handshake             payload
//   ray      in         ray_valid/ray_stall   normal and incident direction (ray_t)
//   refl     out        refl_valid/refl_stall reflected direction and angle (refl_t)
//
// One request is taken every cycle while ray_stall is low; a result passes through
// 7 stages of reflection, 33 of square root, 32 of rotation and rounding,
// and the output buffer.
// Reset clears only the valid bits and the buffer count; no state is kept.
// A stalled output fills the two-entry buffer first; only then does ray_stall rise
// and the whole pipeline hold.
`default_nettype none

module vector_specular_reflection_unit #(
	parameter int FRAC_BITS = 14
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           ray_valid,
	output logic           ray_stall,
	input  vsr_pkg::ray_t  ray,
	output logic           refl_valid,
	input  logic           refl_stall,
	output vsr_pkg::refl_t refl
);
	import vsr_pkg::*;

	logic                   adv;
	logic                   full;

	logic                   rf_valid;
	dir_t                   rf_dir;
	logic signed [XQ_W-1:0] rf_xq;

	logic                   sq_valid;
	dir_t                   sq_dir;
	logic signed [XQ_W-1:0] sq_xq;
	logic        [Y_W-1:0]  sq_y;

	logic                   cr_valid;
	refl_t                  cr_result;

	assign adv       = !full;
	assign ray_stall = full;

	vsr_reflect #(
		.FRAC_BITS(FRAC_BITS)
	) u_reflect (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (ray_valid),
		.ray      (ray),
		.out_valid(rf_valid),
		.dir      (rf_dir),
		.xq       (rf_xq)
	);

	vsr_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (rf_valid),
		.dir_in   (rf_dir),
		.xq_in    (rf_xq),
		.out_valid(sq_valid),
		.dir_out  (sq_dir),
		.xq_out   (sq_xq),
		.y        (sq_y)
	);

	vsr_cordic #(
		.FRAC_BITS(FRAC_BITS)
	) u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (sq_valid),
		.dir_in   (sq_dir),
		.xq_in    (sq_xq),
		.y_in     (sq_y),
		.out_valid(cr_valid),
		.result   (cr_result)
	);

	vsr_out_buf u_out_buf (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (cr_valid && adv),
		.din   (cr_result),
		.valid (refl_valid),
		.stall (refl_stall),
		.dout  (refl),
		.full  (full)
	);

`ifndef SYNTH
	// The input is held off only while results are waiting at the output.
	assert property (@(posedge clk) disable iff (!arst_n)
		ray_stall |-> refl_valid)
		else $error("request stalled with no result waiting");

	// The input stall can only be released by a result leaving.
	assert property (@(posedge clk) disable iff (!arst_n)
		$fell(ray_stall) |-> $past(refl_valid && !refl_stall))
		else $error("request stall released without a result taken");

	// The input stall can only rise while a result is already held.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ray_stall) |-> $past(refl_valid && refl_stall))
		else $error("request stall raised without a held result");
`endif

endmodule

`default_nettype wire

// ===== tb/vector_specular_reflection_unit_tb.sv =====
// Self-checking testbench for the 2D specular reflection unit with reflection angle.
`default_nettype none

module vector_specular_reflection_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import vsr_pkg::*;

	localparam int FRAC = 14;
	localparam int ROT_STEPS = 30;
	localparam longint ONE_Q30 = 64'sd1073741824;
	localparam longint QUARTER_TURN_Q30 = 64'sd1686629713;
	localparam real TWO_PI = 6.283185307179586;
	localparam int RANDOM_RAYS = 1000;
	localparam int DRAIN_CYCLES = 100;

	// Arctangent of 2^-i in Q30, entry zero first.
	localparam bit [ROT_STEPS*32-1:0] ATAN_TBL = {
		32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
		32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
		32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
		32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
		32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
		32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002
	};

	class refl_tracker;
		refl_t pending_refl[$];
		int unsigned error_count;

		function longint round_shift(longint v, int s);
			if (s == 0)
				return v;
			return (v + (longint'(1) << (s - 1))) >>> s;
		endfunction

		function longint clamp16(longint v);
			if (v > 32767)
				return 32767;
			if (v < -32768)
				return -32768;
			return v;
		endfunction

		function refl_t reflect_ray(ray_t r);
			longint nr, nz, ir, iz, dot, rr, rz, d, lim, xq, cx, cy, xs, ys, tmp, ang;
			longint unsigned rad, root, probe;
			int i;
			refl_t res;
			nr = longint'(r.normal_r);
			nz = longint'(r.normal_z);
			ir = longint'(r.incident_r);
			iz = longint'(r.incident_z);
			dot = nr * ir + nz * iz;
			rr = clamp16(ir - round_shift(2 * dot * nr, 2 * FRAC));
			rz = clamp16(iz - round_shift(2 * dot * nz, 2 * FRAC));

			// Cosine of the angle, held to [-1, 1] and moved to Q30.
			d = nr * rr + nz * rz;
			lim = longint'(1) << (2 * FRAC);
			if (d > lim)
				d = lim;
			if (d < -lim)
				d = -lim;
			if (2 * FRAC >= 30)
				xq = round_shift(d, 2 * FRAC - 30);
			else
				xq = d * (longint'(1) << (30 - 2 * FRAC));
			if (xq > ONE_Q30)
				xq = ONE_Q30;
			if (xq < -ONE_Q30)
				xq = -ONE_Q30;

			// Sine by integer square root of 1 - x*x.
			rad = longint'(ONE_Q30 * ONE_Q30 - xq * xq);
			root = 0;
			probe = 64'd1 << 62;
			while (probe > rad)
				probe >>= 2;
			while (probe != 0) begin
				if (rad >= root + probe) begin
					rad -= root + probe;
					root = (root >> 1) + probe;
				end else begin
					root >>= 1;
				end
				probe >>= 2;
			end

			// Vectoring rotation drives the sine to zero and sums the angle.
			cx = xq;
			cy = longint'(root);
			ang = 0;
			if (cx < 0) begin
				tmp = cx;
				cx = cy;
				cy = -tmp;
				ang = QUARTER_TURN_Q30;
			end
			for (i = 0; i < ROT_STEPS; i++) begin
				xs = cx >>> i;
				ys = cy >>> i;
				if (cy > 0) begin
					cx = cx + ys;
					cy = cy - xs;
					ang += longint'(ATAN_TBL[(ROT_STEPS - 1 - i) * 32 +: 32]);
				end else if (cy < 0) begin
					cx = cx - ys;
					cy = cy + xs;
					ang -= longint'(ATAN_TBL[(ROT_STEPS - 1 - i) * 32 +: 32]);
				end
			end
			ang = round_shift(ang, 30 - FRAC);
			if (ang < 0)
				ang = 0;
			if (ang > 65535)
				ang = 65535;

			res.reflected_r = rr[15:0];
			res.reflected_z = rz[15:0];
			res.angle = ang[15:0];
			return res;
		endfunction

		function void note_request(ray_t r);
			pending_refl.push_back(reflect_ray(r));
		endfunction

		function void check_result(refl_t got);
			refl_t want;
			if (pending_refl.size() == 0) begin
				if (error_count < 10)
					$display("%t: result with no request outstanding: r=%0d z=%0d angle=%0d",
						$realtime, got.reflected_r, got.reflected_z, got.angle);
				error_count++;
			end else begin
				want = pending_refl.pop_front();
				if (got.reflected_r !== want.reflected_r || got.reflected_z !== want.reflected_z ||
						got.angle !== want.angle) begin
					if (error_count < 10)
						$display("%t: mismatch: expected r=%0d z=%0d angle=%0d, got r=%0d z=%0d angle=%0d",
							$realtime, want.reflected_r, want.reflected_z, want.angle,
							got.reflected_r, got.reflected_z, got.angle);
					error_count++;
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic ray_valid = 1'b0;
	logic ray_stall;
	ray_t ray = '0;
	logic refl_valid;
	logic refl_stall = 1'b0;
	refl_t refl;

	refl_tracker book;
	bit idle_on = 1'b1;
	int stall_left = 0;

	vector_specular_reflection_unit #(
		.FRAC_BITS(FRAC)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.ray_valid(ray_valid),
		.ray_stall(ray_stall),
		.ray(ray),
		.refl_valid(refl_valid),
		.refl_stall(refl_stall),
		.refl(refl)
	);

	always #4 clk = ~clk;

	initial begin
		#2000000;
		$display("vector_specular_reflection_unit test failed");
		$finish;
	end

	// Output back-pressure in bursts of random length, started only while idle_on is set.
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			refl_stall <= 1'b1;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(0, 18);
			refl_stall <= 1'b1;
		end else begin
			refl_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n && refl_valid && !refl_stall)
			book.check_result(refl);
	end

	function automatic logic [15:0] corner_value();
		case ($urandom_range(0, 7))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'hFFFF;
			4: return 16'h0001;
			5: return 16'h4000;
			6: return 16'hC000;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic offer_ray(input ray_t r);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			ray_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		ray_valid <= 1'b1;
		ray <= r;
		@(posedge clk);
		while (ray_stall !== 1'b0)
			@(posedge clk);
		book.note_request(r);
	endtask

	initial begin
		ray_t cand;
		real theta, phi, amp;
		int k;
		book = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Head-on, grazing, exact plus and minus one, saturation, and non-unit vectors.
		offer_ray('{16'sd0, 16'sd0, 16'sd0, 16'sd0});
		offer_ray('{16'sd16384, 16'sd0, -16'sd16384, 16'sd0});
		offer_ray('{16'sd0, 16'sd16384, 16'sd11585, -16'sd11585});
		offer_ray('{16'sd16384, 16'sd0, 16'sd0, 16'sd16384});
		offer_ray('{-16'sd16384, 16'sd0, 16'sd16384, 16'sd0});
		offer_ray('{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767});
		offer_ray('{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768});
		offer_ray('{-16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768});
		offer_ray('{16'sd32767, 16'sd0, -16'sd32768, 16'sd0});
		offer_ray('{16'sd16384, 16'sd0, 16'sd32767, 16'sd0});
		offer_ray('{16'sd8192, 16'sd0, 16'sd0, 16'sd16384});
		offer_ray('{16'sd4, 16'sd0, -16'sd32768, 16'sd32767});
		offer_ray('{16'sd16384, 16'sd0, 16'sd16384, 16'sd0});
		offer_ray('{16'sd11585, 16'sd11585, -16'sd16384, 16'sd0});
		offer_ray('{16'sd0, -16'sd16384, 16'sd100, -16'sd200});
		offer_ray('{16'sd1, 16'sd1, 16'sd1, 16'sd1});
		offer_ray('{-16'sd1, -16'sd1, -16'sd32768, 16'sd32767});
		offer_ray('{16'sd16384, 16'sd0, -16'sd8192, 16'sd100});
		offer_ray('{16'sd20000, 16'sd0, -16'sd16384, 16'sd0});
		offer_ray('{16'sd0, 16'sd16384, 16'sd0, 16'sd16384});

		for (k = 0; k < RANDOM_RAYS; k++) begin
			if (k % 100 == 0)
				idle_on = (k < RANDOM_RAYS - 200) && ($urandom_range(0, 3) != 0);
			case ($urandom_range(0, 9))
				6, 7: cand = {$urandom(), $urandom()};
				8: cand = {corner_value(), corner_value(), corner_value(), corner_value()};
				9: begin
					cand.normal_r = 16'(int'($urandom_range(0, 127)) - 64);
					cand.normal_z = 16'(int'($urandom_range(0, 127)) - 64);
					cand.incident_r = 16'(int'($urandom_range(0, 127)) - 64);
					cand.incident_z = 16'(int'($urandom_range(0, 127)) - 64);
				end
				default: begin
					// Unit normal and an incident direction of random length.
					theta = $urandom / 4294967296.0 * TWO_PI;
					phi = $urandom / 4294967296.0 * TWO_PI;
					amp = real'($urandom_range(1024, 32767));
					cand.normal_r = 16'($rtoi(16384.0 * $cos(theta)));
					cand.normal_z = 16'($rtoi(16384.0 * $sin(theta)));
					cand.incident_r = 16'($rtoi(amp * $cos(phi)));
					cand.incident_z = 16'($rtoi(amp * $sin(phi)));
				end
			endcase
			offer_ray(cand);
		end
		ray_valid <= 1'b0;
		idle_on = 1'b0;

		while (book.pending_refl.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (book.error_count == 0)
			$display("vector_specular_reflection_unit test passed");
		else
			$display("vector_specular_reflection_unit test failed");
		$finish;
	end

endmodule

`default_nettype wire

// ===== vector_specular_reflection_unit.f =====
src/vsr_pkg.sv
src/vsr_reflect.sv
src/vsr_isqrt.sv
src/vsr_cordic.sv
src/vsr_out_buf.sv
src/vector_specular_reflection_unit.sv
tb/vector_specular_reflection_unit_tb.sv
